// ----- hdl/psd_pkg.sv -----
package psd_pkg;

    // Default sizes of the pixel stores and of the window.
    localparam int PSD_MAX_WIDTH    = 128;
    localparam int PSD_MAX_HEIGHT   = 128;
    localparam int PSD_MAX_CHANNELS = 3;
    localparam int PSD_MAX_RADIUS   = 7;

    // Field widths that the interface fixes.
    localparam int PSD_COORD_W = 8;
    localparam int PSD_DIST_W  = 26;
    localparam int PSD_PIX_W   = 8;
    localparam int PSD_CFG_W   = 8;
    localparam int PSD_IDX_W   = 3;

    // Operation and image select codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam logic IMG_REF  = 1'b0;
    localparam logic IMG_CAND = 1'b1;

    // Configuration register indexes.
    typedef enum logic [PSD_IDX_W-1:0] {
        CFG_RADIUS   = 3'd0,
        CFG_CHANNELS = 3'd1,
        CFG_REF_W    = 3'd2,
        CFG_REF_H    = 3'd3,
        CFG_CAND_W   = 3'd4,
        CFG_CAND_H   = 3'd5
    } t_psd_cfg_idx;

    typedef struct packed {
        logic [2:0] window_radius;
        logic [1:0] channel_count;
        logic [7:0] ref_width;
        logic [7:0] ref_height;
        logic [7:0] cand_width;
        logic [7:0] cand_height;
    } t_psd_cfg;

    typedef struct packed {
        logic       op;
        logic       image_sel;
        logic [1:0] channel;
        logic [6:0] pix_x;
        logic [6:0] pix_y;
        logic [7:0] pixel;
        logic [6:0] ref_x;
        logic [6:0] ref_y;
        logic [6:0] cand_x;
        logic [6:0] cand_y;
    } t_psd_in;

    typedef struct packed {
        logic [PSD_DIST_W-1:0] distance;
        logic                  range_error;
    } t_psd_out;

    // Control from the sequencer to the accumulator, aligned with the read address.
    typedef struct packed {
        logic clr;
        logic vld;
        logic last;
    } t_psd_acc_ctl;

endpackage

// ----- hdl/psd_mem.sv -----
module psd_mem #(
    parameter int A_W   = 16,
    parameter int DEPTH = 49152
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [A_W-1:0]                i_waddr,
    input  logic [psd_pkg::PSD_PIX_W-1:0] i_wdata,
    input  logic                          i_re,
    input  logic [A_W-1:0]                i_raddr,
    output logic [psd_pkg::PSD_PIX_W-1:0] o_rdata
);
    import psd_pkg::*;

    logic [PSD_PIX_W-1:0] r_mem [DEPTH];
    logic [PSD_PIX_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/psd_acc.sv -----
module psd_acc (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  psd_pkg::t_psd_acc_ctl          i_ctl,
    input  logic [psd_pkg::PSD_PIX_W-1:0]  i_ref_pix,
    input  logic [psd_pkg::PSD_PIX_W-1:0]  i_cand_pix,
    output logic                           o_done,
    output logic [psd_pkg::PSD_DIST_W-1:0] o_sum
);
    import psd_pkg::*;

    logic                    r_v1, r_l1, r_v2, r_l2, r_done;
    logic [2*PSD_PIX_W-1:0]  r_sq;
    logic [PSD_DIST_W-1:0]   r_sum;
    logic [PSD_PIX_W-1:0]    w_diff;

    // Control follows the memory read latency, then the squaring stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_l1   <= 1'b0;
            r_v2   <= 1'b0;
            r_l2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_ctl.vld;
            r_l1   <= i_ctl.last;
            r_v2   <= r_v1;
            r_l2   <= r_l1;
            r_done <= r_v2 && r_l2;
        end
    end

    // Absolute difference of the two pixels read last cycle.
    assign w_diff = (i_ref_pix > i_cand_pix) ? (i_ref_pix - i_cand_pix)
                                             : (i_cand_pix - i_ref_pix);

    always_ff @(posedge i_clk) begin
        r_sq <= (2*PSD_PIX_W)'(w_diff) * (2*PSD_PIX_W)'(w_diff);
    end

    // Running sum, wrapping at the result width.
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_sum <= '0;
        end else if (r_v2) begin
            r_sum <= r_sum + PSD_DIST_W'(r_sq);
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_sum;

endmodule

// ----- hdl/psd_ctrl.sv -----
module psd_ctrl #(
    parameter int MAX_WIDTH    = psd_pkg::PSD_MAX_WIDTH,
    parameter int MAX_HEIGHT   = psd_pkg::PSD_MAX_HEIGHT,
    parameter int MAX_CHANNELS = psd_pkg::PSD_MAX_CHANNELS,
    parameter int MAX_RADIUS   = psd_pkg::PSD_MAX_RADIUS,
    localparam int X_W  = $clog2(MAX_WIDTH),
    localparam int Y_W  = $clog2(MAX_HEIGHT),
    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    localparam int A_W  = CH_W + Y_W + X_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  psd_pkg::t_psd_cfg              i_cfg,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  psd_pkg::t_psd_in               i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output psd_pkg::t_psd_out              o_out_data,
    output logic                           o_ref_we,
    output logic                           o_cand_we,
    output logic [A_W-1:0]                 o_waddr,
    output logic [psd_pkg::PSD_PIX_W-1:0]  o_wdata,
    output logic                           o_rd_en,
    output logic [A_W-1:0]                 o_ref_raddr,
    output logic [A_W-1:0]                 o_cand_raddr,
    output psd_pkg::t_psd_acc_ctl          o_acc,
    input  logic                           i_acc_done,
    input  logic [psd_pkg::PSD_DIST_W-1:0] i_sum
);
    import psd_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_DONE} t_state;

    t_state           r_state;
    logic             r_out_valid;
    t_psd_out         r_out_data;
    logic             r_range;
    logic [X_W-1:0]   r_rx, r_cx, r_rbx, r_cbx;
    logic [Y_W-1:0]   r_ry, r_cy, r_rby, r_cby;
    logic [3:0]       r_dx, r_dy;
    logic [CH_W-1:0]  r_ch;

    logic       w_accept, w_query, w_wr_ok, w_fits, w_last;
    logic [2:0] w_r, w_nch;
    logic [3:0] w_two_r;
    logic [7:0] w_rw, w_rh, w_cw, w_chh;

    // Window [c - r, c + r] lies inside [0, size).
    function automatic logic fits(input logic [6:0] c, input logic [2:0] r,
                                  input logic [7:0] size);
        logic [8:0] hi;
        hi = 9'(c) + 9'(r);
        return (c >= 7'(r)) && (hi < 9'(size));
    endfunction

    // Effective settings after saturation.
    always_comb begin
        w_r     = (i_cfg.window_radius > MAX_RADIUS) ? 3'(MAX_RADIUS) : i_cfg.window_radius;
        w_nch   = (i_cfg.channel_count > MAX_CHANNELS) ? 3'(MAX_CHANNELS)
                                                       : 3'(i_cfg.channel_count);
        w_rw    = (i_cfg.ref_width > MAX_WIDTH) ? 8'(MAX_WIDTH) : i_cfg.ref_width;
        w_rh    = (i_cfg.ref_height > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : i_cfg.ref_height;
        w_cw    = (i_cfg.cand_width > MAX_WIDTH) ? 8'(MAX_WIDTH) : i_cfg.cand_width;
        w_chh   = (i_cfg.cand_height > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : i_cfg.cand_height;
        w_two_r = {w_r, 1'b0};
    end

    // Input transfer and the range check of a query.
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_query    = w_accept && (i_in_data.op == OP_QUERY);
    assign w_fits     = fits(i_in_data.ref_x, w_r, w_rw) && fits(i_in_data.ref_y, w_r, w_rh) &&
                        fits(i_in_data.cand_x, w_r, w_cw) && fits(i_in_data.cand_y, w_r, w_chh);

    // Pixel writes go straight to the selected store.
    assign w_wr_ok   = (i_in_data.channel < MAX_CHANNELS) && (i_in_data.pix_x < MAX_WIDTH) &&
                       (i_in_data.pix_y < MAX_HEIGHT);
    assign o_ref_we  = w_accept && (i_in_data.op == OP_WRITE) &&
                       (i_in_data.image_sel == IMG_REF) && w_wr_ok;
    assign o_cand_we = w_accept && (i_in_data.op == OP_WRITE) &&
                       (i_in_data.image_sel == IMG_CAND) && w_wr_ok;
    assign o_waddr   = {CH_W'(i_in_data.channel), Y_W'(i_in_data.pix_y), X_W'(i_in_data.pix_x)};
    assign o_wdata   = i_in_data.pixel;

    // One pixel pair read per cycle while the window is walked.
    assign w_last       = (r_state == S_RUN) && (r_dx == w_two_r) && (r_dy == w_two_r) &&
                          (3'(r_ch) == (w_nch - 3'd1));
    assign o_rd_en      = (r_state == S_RUN);
    assign o_ref_raddr  = {r_ch, r_ry, r_rx};
    assign o_cand_raddr = {r_ch, r_cy, r_cx};
    assign o_acc.clr    = w_query;
    assign o_acc.vld    = (r_state == S_RUN);
    assign o_acc.last   = w_last;

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // The finishing state loads the output register itself.
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_query) begin
                        r_range <= !w_fits;
                        r_rbx   <= X_W'(PSD_COORD_W'(i_in_data.ref_x) - PSD_COORD_W'(w_r));
                        r_cbx   <= X_W'(PSD_COORD_W'(i_in_data.cand_x) - PSD_COORD_W'(w_r));
                        r_rby   <= Y_W'(PSD_COORD_W'(i_in_data.ref_y) - PSD_COORD_W'(w_r));
                        r_cby   <= Y_W'(PSD_COORD_W'(i_in_data.cand_y) - PSD_COORD_W'(w_r));
                        r_rx    <= X_W'(PSD_COORD_W'(i_in_data.ref_x) - PSD_COORD_W'(w_r));
                        r_cx    <= X_W'(PSD_COORD_W'(i_in_data.cand_x) - PSD_COORD_W'(w_r));
                        r_ry    <= Y_W'(PSD_COORD_W'(i_in_data.ref_y) - PSD_COORD_W'(w_r));
                        r_cy    <= Y_W'(PSD_COORD_W'(i_in_data.cand_y) - PSD_COORD_W'(w_r));
                        r_dx    <= '0;
                        r_dy    <= '0;
                        r_ch    <= '0;
                        if (!w_fits || (w_nch == 3'd0)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (r_dx == w_two_r) begin
                        r_dx <= '0;
                        r_rx <= r_rbx;
                        r_cx <= r_cbx;
                        if (r_dy == w_two_r) begin
                            r_dy <= '0;
                            r_ry <= r_rby;
                            r_cy <= r_cby;
                            r_ch <= r_ch + 1'b1;
                        end else begin
                            r_dy <= r_dy + 4'd1;
                            r_ry <= r_ry + 1'b1;
                            r_cy <= r_cy + 1'b1;
                        end
                    end else begin
                        r_dx <= r_dx + 4'd1;
                        r_rx <= r_rx + 1'b1;
                        r_cx <= r_cx + 1'b1;
                    end
                    if (w_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (i_acc_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid            <= 1'b1;
                        r_out_data.distance    <= r_range ? '0 : i_sum;
                        r_out_data.range_error <= r_range;
                        r_state                <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- hdl/patch_squared_distance_core.sv -----
// Channel   Direction  Handshake          Payload
// in        input      valid / stall      t_psd_in (pixel write or query)
// out       output     valid / stall      t_psd_out (distance, range_error)
// cfg       input      valid / ready      3-bit register index, 8-bit data
//
// A query whose windows fit reads channels * (2 * radius + 1)^2 pixel pairs through
// the single read port of each pixel store: one pixel pair is read per cycle. A
// query that leaves an image or sums no channel goes from idle straight to the
// finishing state and reads no pixel. Reset is synchronous and active low; the
// pixel stores are not cleared. A new item is taken while a result waits in the
// output register; only the finish of a query waits for that register to empty.
module patch_squared_distance_core #(
    parameter int MAX_WIDTH    = psd_pkg::PSD_MAX_WIDTH,
    parameter int MAX_HEIGHT   = psd_pkg::PSD_MAX_HEIGHT,
    parameter int MAX_CHANNELS = psd_pkg::PSD_MAX_CHANNELS,
    parameter int MAX_RADIUS   = psd_pkg::PSD_MAX_RADIUS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  psd_pkg::t_psd_in              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output psd_pkg::t_psd_out             o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [psd_pkg::PSD_IDX_W-1:0] i_cfg_index,
    input  logic [psd_pkg::PSD_CFG_W-1:0] i_cfg_data
);
    import psd_pkg::*;

    localparam int X_W   = $clog2(MAX_WIDTH);
    localparam int Y_W   = $clog2(MAX_HEIGHT);
    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int A_W   = CH_W + Y_W + X_W;
    localparam int DEPTH = MAX_CHANNELS << (Y_W + X_W);

    t_psd_cfg              r_cfg;
    t_psd_acc_ctl          w_acc;
    logic                  w_ref_we, w_cand_we, w_rd_en, w_acc_done;
    logic [A_W-1:0]        w_waddr, w_ref_raddr, w_cand_raddr;
    logic [PSD_PIX_W-1:0]  w_wdata, w_ref_pix, w_cand_pix;
    logic [PSD_DIST_W-1:0] w_sum;

    // Configuration registers; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_radius <= 3'd3;
            r_cfg.channel_count <= 2'd1;
            r_cfg.ref_width     <= 8'd128;
            r_cfg.ref_height    <= 8'd128;
            r_cfg.cand_width    <= 8'd128;
            r_cfg.cand_height   <= 8'd128;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_psd_cfg_idx'(i_cfg_index))
                CFG_RADIUS:   r_cfg.window_radius <= i_cfg_data[2:0];
                CFG_CHANNELS: r_cfg.channel_count <= i_cfg_data[1:0];
                CFG_REF_W:    r_cfg.ref_width     <= i_cfg_data;
                CFG_REF_H:    r_cfg.ref_height    <= i_cfg_data;
                CFG_CAND_W:   r_cfg.cand_width    <= i_cfg_data;
                CFG_CAND_H:   r_cfg.cand_height   <= i_cfg_data;
                default:      r_cfg               <= r_cfg;
            endcase
        end
    end

    // Sequencer.
    psd_ctrl #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_CHANNELS(MAX_CHANNELS),
        .MAX_RADIUS  (MAX_RADIUS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_ref_we    (w_ref_we),
        .o_cand_we   (w_cand_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_rd_en     (w_rd_en),
        .o_ref_raddr (w_ref_raddr),
        .o_cand_raddr(w_cand_raddr),
        .o_acc       (w_acc),
        .i_acc_done  (w_acc_done),
        .i_sum       (w_sum)
    );

    // Reference and candidate pixel stores.
    psd_mem #(.A_W(A_W), .DEPTH(DEPTH)) u_ref_mem (
        .i_clk  (i_clk),
        .i_we   (w_ref_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_rd_en),
        .i_raddr(w_ref_raddr),
        .o_rdata(w_ref_pix)
    );

    psd_mem #(.A_W(A_W), .DEPTH(DEPTH)) u_cand_mem (
        .i_clk  (i_clk),
        .i_we   (w_cand_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_rd_en),
        .i_raddr(w_cand_raddr),
        .o_rdata(w_cand_pix)
    );

    // Squared difference and sum.
    psd_acc u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_acc),
        .i_ref_pix (w_ref_pix),
        .i_cand_pix(w_cand_pix),
        .o_done    (w_acc_done),
        .o_sum     (w_sum)
    );

    // A window walk never overlaps a pixel write.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> !(w_ref_we || w_cand_we))
        else $error("pixel store read and write in the same cycle");

    // Reads only happen while the input side is held off.
    a_read_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc.vld |-> o_in_stall)
        else $error("window read while input is open");

    // A range error always comes with a zero distance.
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.range_error) |-> (o_out_data.distance == '0))
        else $error("range error with nonzero distance");

    // The accumulator finishes only after the last read of a walk.
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_done |-> $past(w_acc.last, 3))
        else $error("accumulator done without a final read");

endmodule
